// File: rtl/slc_pkg.sv
package slc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_COUNT_LOG2   = 2'd2;

    localparam logic [3:0] WAYS_RESET      = 4'd1;
    localparam logic [2:0] BLOCK_LOG2_RESET = 3'd2;
    localparam logic [3:0] SETS_LOG2_RESET  = 4'd9;

    // Way count compare width: holds up to 31
    localparam int WCNT_W = 5;

    localparam int AGE_W = 8;
    localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0] ways_in_use;
        logic [2:0] block_bytes_log2;
        logic [3:0] set_count_log2;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_EVAL  = 3'b100
    } back_state_t;

    // Index width with a floor of one bit
    function automatic int idx_width(input int n);
        int w;
        w = $clog2(n);
        return (w < 1) ? 1 : w;
    endfunction

endpackage

// File: rtl/slc_front.sv
module slc_front #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_SETS  = 512,
    parameter int SET_W     = 9,
    parameter int TAG_W     = 32
) (
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [31:0]            address,
    input  slc_pkg::cfg_t          cfg,
    input  slc_pkg::q_stat_t       q_stat,
    input  logic                   back_ready,
    output logic                   push,
    output logic [SET_W+TAG_W-1:0] entry
);
    import slc_pkg::*;

    localparam int EA_W     = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int XW       = (EA_W > SET_W) ? EA_W : SET_W;
    localparam int SLOG_MAX = $clog2(MAX_SETS + 1) - 1;

    logic [3:0]    slog_eff;
    logic [XW-1:0] ea_x;
    logic [XW-1:0] blk;
    logic [XW-1:0] set_mask;
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;

    always_comb
    begin
        slog_eff = cfg.set_count_log2;
        if (cfg.set_count_log2 > 4'(SLOG_MAX))
        begin
            slog_eff = 4'(SLOG_MAX);
        end
        ea_x     = XW'(address[EA_W-1:0]);
        blk      = ea_x >> cfg.block_bytes_log2;
        set_mask = (XW'(1) << slog_eff) - XW'(1);
        set_idx  = SET_W'(blk & set_mask);
        tag      = TAG_W'(blk >> slog_eff);
    end

    assign req_stall = q_stat.full || !back_ready;
    assign push      = req_valid && !req_stall;
    assign entry     = {set_idx, tag};

endmodule

// File: rtl/slc_queue.sv
module slc_queue #(
    parameter int WIDTH = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output slc_pkg::q_stat_t stat
);
    import slc_pkg::*;

    localparam int PTR_W = idx_width(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: rtl/slc_back.sv
module slc_back #(
    parameter int MAX_WAYS = 8,
    parameter int MAX_SETS = 512,
    parameter int SET_W    = 9,
    parameter int TAG_W    = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  slc_pkg::cfg_t          cfg,
    input  slc_pkg::q_stat_t       q_stat,
    input  logic [SET_W+TAG_W-1:0] q_head,
    output logic                   pop,
    output logic                   ready,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   hit,
    output logic [2:0]             way_used
);
    import slc_pkg::*;

    localparam int WAY_W = idx_width(MAX_WAYS);
    localparam logic [WCNT_W-1:0] WAYS_CAP = WCNT_W'(MAX_WAYS);
    localparam logic [SET_W-1:0]  LAST_SET = SET_W'(MAX_SETS - 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
    } row_t;

    row_t mem_ram [MAX_SETS];

    back_state_t      state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    row_t             rd_row_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;

    logic [WCNT_W-1:0]   ways_eff;
    logic [MAX_WAYS-1:0] in_use;
    logic                hit_found;
    logic [WAY_W-1:0]    hit_way;
    logic                inv_found;
    logic [WAY_W-1:0]    inv_way;
    logic                have_best;
    logic [AGE_W-1:0]    best_age;
    logic [WAY_W-1:0]    best_way;
    logic [WAY_W-1:0]    used_way;
    row_t                new_row;
    logic                load;
    logic                wr_en;
    logic [SET_W-1:0]    wr_addr;
    row_t                wr_row;

    // Lookup and update of the set row registered when its entry was popped
    always_comb
    begin
        ways_eff = {1'b0, cfg.ways_in_use};
        if (cfg.ways_in_use == '0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (ways_eff > WAYS_CAP)
        begin
            ways_eff = WAYS_CAP;
        end

        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        have_best = 1'b0;
        best_age  = '0;
        best_way  = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (WCNT_W'(i) < ways_eff);
            if (in_use[i] && rd_row_reg.valid[i] && !hit_found &&
                rd_row_reg.tag[i] == tag_reg)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
            if (in_use[i] && !rd_row_reg.valid[i] && !inv_found)
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(i);
            end
            if (in_use[i] && rd_row_reg.valid[i] &&
                (!have_best || rd_row_reg.age[i] > best_age))
            begin
                have_best = 1'b1;
                best_age  = rd_row_reg.age[i];
                best_way  = WAY_W'(i);
            end
        end

        if (hit_found)
        begin
            used_way = hit_way;
        end
        else if (inv_found)
        begin
            used_way = inv_way;
        end
        else
        begin
            used_way = best_way;
        end

        new_row = rd_row_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_W'(i) == used_way)
            begin
                new_row.age[i] = '0;
                if (!hit_found)
                begin
                    new_row.valid[i] = 1'b1;
                    new_row.tag[i]   = tag_reg;
                end
            end
            else if (in_use[i] && rd_row_reg.valid[i] && rd_row_reg.age[i] != AGE_MAX)
            begin
                new_row.age[i] = rd_row_reg.age[i] + AGE_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pop          = 1'b0;
        load         = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = set_reg;
        wr_row       = new_row;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_row  = '0;
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + SET_W'(1);
                end
            end
            ST_READ:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load       = 1'b1;
                    wr_en      = 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        rsp_valid_next = load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_row;
        end
        if (pop)
        begin
            rd_row_reg <= mem_ram[q_head[SET_W+TAG_W-1:TAG_W]];
            set_reg    <= q_head[SET_W+TAG_W-1:TAG_W];
            tag_reg    <= q_head[TAG_W-1:0];
        end
        if (load)
        begin
            hit_reg <= hit_found;
            way_reg <= used_way;
        end
    end

    assign ready     = (state_reg != ST_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign hit       = hit_reg;
    assign way_used  = 3'(way_reg);

    a_rsp_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EVAL))
        else $error("result appeared without a lookup");

    a_way_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (WCNT_W'(way_reg) < ways_eff))
        else $error("reported way outside the ways in use");

    a_used_way_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> new_row.valid[used_way] && new_row.age[used_way] == '0)
        else $error("written row does not hold the used way as newest");

    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_cnt_reg != LAST_SET) |=>
            (state_reg == ST_CLEAR && !rsp_valid_reg))
        else $error("clearing pass ended early");

endmodule

// File: rtl/set_assoc_lru_cache_lookup_core.sv
// Set-associative cache lookup with age-counter LRU replacement.
// req channel: one byte address per transaction (req_valid / req_stall).
// rsp channel: hit flag and way used per transaction (rsp_valid / rsp_stall).
// cfg channel: cfg_valid / cfg_ready write of ways in use, block size log2 and
//   set count log2; cfg_ready is always high. Write only while the block is idle.
// Addresses are decoded and queued (two entries) in front of a sequencer that
// reads the set row from a single-port memory, then writes back valid bits,
// tags and ages. Each transaction passes through ST_READ, for the row read, and
// ST_EVAL, for the compare and write back; no new address is popped until the
// sequencer is back in ST_READ. The set row is registered on the pop and the
// result is registered when ST_EVAL completes.
// After reset the memory is cleared one set per cycle, for all MAX_SETS sets;
// req_stall is high during that pass.
// When rsp_stall holds a result, the sequencer keeps its next lookup waiting
// and the queue keeps taking addresses until full, then req_stall rises.
module set_assoc_lru_cache_lookup_core #(
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 512,
    parameter int ADDR_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [31:0]                    address,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           hit,
    output logic [2:0]                     way_used,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slc_pkg::*;

    localparam int SET_W = idx_width(MAX_SETS);
    localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int QW    = SET_W + TAG_W;

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    logic    back_ready;
    logic [QW-1:0] push_entry;
    logic [QW-1:0] q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ways_in_use      <= WAYS_RESET;
            cfg_reg.block_bytes_log2 <= BLOCK_LOG2_RESET;
            cfg_reg.set_count_log2   <= SETS_LOG2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WAYS_IN_USE:      cfg_reg.ways_in_use      <= cfg_data[3:0];
                CFG_BLOCK_BYTES_LOG2: cfg_reg.block_bytes_log2 <= cfg_data[2:0];
                CFG_SET_COUNT_LOG2:   cfg_reg.set_count_log2   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    slc_front #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SETS  (MAX_SETS),
        .SET_W     (SET_W),
        .TAG_W     (TAG_W)
    ) u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .address    (address),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .back_ready (back_ready),
        .push       (push),
        .entry      (push_entry)
    );

    slc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    slc_back #(
        .MAX_WAYS (MAX_WAYS),
        .MAX_SETS (MAX_SETS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .pop       (pop),
        .ready     (back_ready),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .hit       (hit),
        .way_used  (way_used)
    );

endmodule
